/* src/tcw_pkg.sv */
package tcw_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 80;
  localparam int unsigned DEF_SCREEN_HEIGHT = 25;
  localparam int unsigned DEF_TAB_STEP      = 4;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned COL_FIELD_W = 7;
  localparam int unsigned ROW_FIELD_W = 5;
  localparam int unsigned CELL_W      = 16;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_USED_W  = CHAR_W + COL_FIELD_W + ROW_FIELD_W;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_USED_W  = COL_FIELD_W + ROW_FIELD_W + CELL_W + 1;
  localparam int unsigned M_PAD_W   = M_TDATA_W - M_USED_W;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_BLANK,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic exec;
    logic blank_step;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scroll;
    logic blank_last;
    logic out_free;
  } tcw_sts_t;

endpackage

/* src/tcw_ram.sv */
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tcw_ctrl.sv */
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  tcw_sts_t sts_i,
  output tcw_cmd_t cmd_o
);

  tcw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.scroll ? ST_BLANK : ST_DONE;
      end
      ST_BLANK: begin
        if (sts_i.blank_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
      end
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_BLANK: cmd_o.blank_step = 1'b1;
      ST_DONE:  cmd_o.load_out = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        s_tready_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/tcw_datapath.sv */
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int unsigned TAB_STEP      = DEF_TAB_STEP
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcw_cmd_t             cmd_i,
  output tcw_sts_t             sts_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 cfg_wr_en_i,
  input  logic [COLOR_W-1:0]   cfg_wr_data_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned CellCount = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned ColW      = $clog2(SCREEN_WIDTH);
  localparam int unsigned RowW      = $clog2(SCREEN_HEIGHT);
  localparam int unsigned ColXW     = $clog2(SCREEN_WIDTH + TAB_STEP);
  localparam int unsigned RowXW     = RowW + 1;

  function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] r,
                                               input logic [RowW-1:0] t);
    logic [RowXW-1:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= RowXW'(SCREEN_HEIGHT)) s = s - RowXW'(SCREEN_HEIGHT);
    return s[RowW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] row_base(input logic [RowW-1:0] r);
    return AddrW'(r) * AddrW'(SCREEN_WIDTH);
  endfunction

  logic                   func_q;
  logic [CHAR_W-1:0]      ch_q;
  logic [COL_FIELD_W-1:0] rcol_q;
  logic [ROW_FIELD_W-1:0] rrow_q;
  logic [COLOR_W-1:0]     color_q;
  logic [ColW-1:0]        col_q, col_d;
  logic [RowW-1:0]        row_q, row_d;
  logic [RowW-1:0]        top_q, top_d;
  logic [AddrW-1:0]       clr_cnt_q;
  logic [ColW-1:0]        blk_col_q, blk_col_d;
  logic [AddrW-1:0]       blk_base_q, blk_base_d;
  logic                   scrolled_q, scrolled_d;
  logic                   rd_ok_q, rd_ok_d;
  logic                   out_valid_q;
  logic [M_TDATA_W-1:0]   out_data_q;

  logic [ColXW-1:0] col_x;
  logic [RowXW-1:0] row_x;
  logic             is_print;
  logic             scroll_now;
  logic             rd_ok;
  logic [AddrW-1:0] put_addr;
  logic [AddrW-1:0] rd_addr;
  logic [CELL_W-1:0] cell_out;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CELL_W-1:0] ram_rdata;

  always_comb begin
    col_x    = ColXW'(col_q);
    row_x    = RowXW'(row_q);
    is_print = 1'b0;
    case (ch_q)
      CH_NEWLINE: begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
      CH_RETURN: col_x = '0;
      CH_BACKSPACE: begin
        if (col_q != '0) col_x = col_x - 1'b1;
      end
      CH_TAB: col_x = col_x + ColXW'(TAB_STEP);
      default: begin
        is_print = 1'b1;
        col_x    = col_x + 1'b1;
      end
    endcase
    if (col_x >= ColXW'(SCREEN_WIDTH)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    scroll_now = (row_x >= RowXW'(SCREEN_HEIGHT));
  end

  assign rd_ok    = (32'(rcol_q) < 32'(SCREEN_WIDTH)) && (32'(rrow_q) < 32'(SCREEN_HEIGHT));
  assign put_addr = row_base(phys_row(row_q, top_q)) + AddrW'(col_q);
  assign rd_addr  = row_base(phys_row(RowW'(rrow_q), top_q)) + AddrW'(rcol_q);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    top_d      = top_q;
    blk_col_d  = blk_col_q;
    blk_base_d = blk_base_q;
    scrolled_d = scrolled_q;
    rd_ok_d    = rd_ok_q;
    ram_we     = 1'b0;
    ram_waddr  = put_addr;
    ram_wdata  = {color_q, ch_q};
    ram_re     = 1'b0;
    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = RESET_CELL;
    end
    if (cmd_i.blank_step) begin
      ram_we    = 1'b1;
      ram_waddr = blk_base_q + AddrW'(blk_col_q);
      ram_wdata = {color_q, CH_SPACE};
      blk_col_d = blk_col_q + 1'b1;
    end
    if (cmd_i.exec) begin
      if (func_q == FUNC_PUT) begin
        ram_we     = is_print;
        scrolled_d = scroll_now;
        if (scroll_now) begin
          col_d      = '0;
          row_d      = RowW'(SCREEN_HEIGHT - 1);
          top_d      = (top_q == RowW'(SCREEN_HEIGHT - 1)) ? '0 : top_q + 1'b1;
          blk_base_d = row_base(top_q);
          blk_col_d  = '0;
        end else begin
          col_d = ColW'(col_x);
          row_d = RowW'(row_x);
        end
      end else begin
        ram_re     = rd_ok;
        rd_ok_d    = rd_ok;
        scrolled_d = 1'b0;
      end
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CellCount)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= RESET_COLOR;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      clr_cnt_q   <= '0;
      blk_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) color_q <= cfg_wr_data_i;
      col_q     <= col_d;
      row_q     <= row_d;
      top_q     <= top_d;
      blk_col_q <= blk_col_d;
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cell_out = (func_q == FUNC_READ && rd_ok_q) ? ram_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= s_tuser_i;
      ch_q   <= s_tdata_i[CHAR_W-1:0];
      rcol_q <= s_tdata_i[CHAR_W +: COL_FIELD_W];
      rrow_q <= s_tdata_i[CHAR_W + COL_FIELD_W +: ROW_FIELD_W];
    end
    blk_base_q <= blk_base_d;
    scrolled_q <= scrolled_d;
    rd_ok_q    <= rd_ok_d;
    if (cmd_i.load_out) begin
      out_data_q <= {{M_PAD_W{1'b0}}, scrolled_q, cell_out,
                     ROW_FIELD_W'(row_q), COL_FIELD_W'(col_q)};
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == AddrW'(CellCount - 1));
  assign sts_o.scroll     = (func_q == FUNC_PUT) && scroll_now;
  assign sts_o.blank_last = (blk_col_q == ColW'(SCREEN_WIDTH - 1));
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

/* src/text_terminal_char_writer.sv */
// Channel   Direction  tdata fields (low bit up)                        tuser
// s_axis    in         char_code[7:0] read_column[14:8] read_row[19:15]  func
// m_axis    out        cursor_column[6:0] cursor_row[11:7]
//                      cell_data[27:12] scrolled[28]                     -
// cfg       in         cfg_wr_en_i / cfg_wr_data_i: text_color, no wait
//
// A read or a put without scroll passes through EXEC and DONE, where its result
// is loaded into the output register once that register is free; the next input
// is taken only after the controller has returned to IDLE.
// A put that scrolls also passes through BLANK to fill the new bottom row with spaces;
// rows are addressed through a rotating top-row pointer, so no copy is made.
// After reset, the CLEAR state fills all SCREEN_WIDTH * SCREEN_HEIGHT cells with grey
// spaces, one cell per cycle, before the first transaction is accepted.
// One result may wait in the output register while the next item is taken.
module text_terminal_char_writer
  import tcw_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int unsigned TAB_STEP      = DEF_TAB_STEP
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // char_code[7:0], read_column[14:8], read_row[19:15], zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // cursor_column[6:0], cursor_row[11:7], cell_data[27:12], scrolled[28], zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_wr_en_i,
  input  logic [COLOR_W-1:0]   cfg_wr_data_i
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tcw_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TAB_STEP     (TAB_STEP)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .m_tready_i   (m_axis_tready),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tdata_o    (m_axis_tdata)
  );

endmodule

/* src/tcw_checker.sv */
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input taken while an item is in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[6:0]) < 32'(SCREEN_WIDTH))
    else $error("Cursor column beyond the screen.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[28] |->
      m_axis_tdata[6:0] == 7'd0 && m_axis_tdata[11:7] == 5'(SCREEN_HEIGHT - 1))
    else $error("Scroll did not leave the cursor at the start of the bottom row.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tdata[27:12] == 16'd0)
    else $error("Scrolling put carries cell data.");

endmodule

bind text_terminal_char_writer tcw_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* dv/text_terminal_char_writer_tb.sv */
`timescale 1ns / 100ps

module text_terminal_char_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned COLS  = DEF_SCREEN_WIDTH;
  localparam int unsigned ROWS  = DEF_SCREEN_HEIGHT;
  localparam int unsigned TAB   = DEF_TAB_STEP;
  localparam int unsigned CELLS = COLS * ROWS;

  typedef struct {
    logic [COL_FIELD_W-1:0] col;
    logic [ROW_FIELD_W-1:0] row;
    logic [CELL_W-1:0]      cell_data;
    logic                   scrolled;
  } term_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_wr_en_i = 1'b0;
  logic [COLOR_W-1:0]   cfg_wr_data_i = '0;

  logic [CELL_W-1:0]  screen_mem [CELLS];
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] text_color_q;

  term_result_t expect_q [$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  err_cnt = 0;
  int unsigned  item_cnt = 0;
  int unsigned  result_cnt = 0;
  int unsigned  read_cnt = 0;
  int unsigned  scroll_cnt = 0;
  int unsigned  cfg_cnt = 0;

  text_terminal_char_writer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic term_result_t predict_terminal(logic func, logic [CHAR_W-1:0] ch,
                                                    logic [COL_FIELD_W-1:0] rcol,
                                                    logic [ROW_FIELD_W-1:0] rrow);
    term_result_t r;
    int unsigned  col;
    int unsigned  row;
    int unsigned  base;
    col = cur_col;
    row = cur_row;
    r.cell_data = '0;
    r.scrolled = 1'b0;
    if (func == FUNC_READ) begin
      if (rcol < COLS && rrow < ROWS) begin
        r.cell_data = screen_mem[rrow * COLS + rcol];
      end
    end else begin
      case (ch)
        CH_NEWLINE: begin
          col = 0;
          row = row + 1;
        end
        CH_RETURN: begin
          col = 0;
        end
        CH_BACKSPACE: begin
          if (col > 0) col = col - 1;
        end
        CH_TAB: begin
          col = col + TAB;
        end
        default: begin
          screen_mem[row * COLS + col] = {text_color_q, ch};
          col = col + 1;
        end
      endcase
      if (col >= COLS) begin
        col = 0;
        row = row + 1;
      end
      if (row >= ROWS) begin
        base = (ROWS - 1) * COLS;
        for (int unsigned i = 0; i < base; i++) screen_mem[i] = screen_mem[i + COLS];
        for (int unsigned i = 0; i < COLS; i++) screen_mem[base + i] = {text_color_q, CH_SPACE};
        col = 0;
        row = ROWS - 1;
        r.scrolled = 1'b1;
        scroll_cnt++;
      end
      cur_col = col;
      cur_row = row;
    end
    r.col = COL_FIELD_W'(col);
    r.row = ROW_FIELD_W'(row);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h", $time, result_cnt, what, got,
             want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    term_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (expect_q.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 0);
      end else begin
        want = expect_q.pop_front();
        if (m_axis_tdata[6:0] !== want.col)
          report_mismatch("cursor_column", m_axis_tdata[6:0], want.col);
        if (m_axis_tdata[11:7] !== want.row)
          report_mismatch("cursor_row", m_axis_tdata[11:7], want.row);
        if (m_axis_tdata[27:12] !== want.cell_data)
          report_mismatch("cell_data", m_axis_tdata[27:12], want.cell_data);
        if (m_axis_tdata[28] !== want.scrolled)
          report_mismatch("scrolled", m_axis_tdata[28], want.scrolled);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic send_item(logic func, logic [CHAR_W-1:0] ch, logic [COL_FIELD_W-1:0] rcol,
                           logic [ROW_FIELD_W-1:0] rrow);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = '0;
    s_axis_tdata[7:0]   = ch;
    s_axis_tdata[14:8]  = rcol;
    s_axis_tdata[19:15] = rrow;
    do @(posedge clk_i); while (!s_axis_tready);
    expect_q.push_back(predict_terminal(func, ch, rcol, rrow));
    item_cnt++;
    if (func == FUNC_READ) read_cnt++;
    @(negedge clk_i);
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_item(FUNC_PUT, ch, COL_FIELD_W'($urandom_range(0, 127)),
              ROW_FIELD_W'($urandom_range(0, 31)));
  endtask

  task automatic read_cell(int unsigned col, int unsigned row);
    send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)), COL_FIELD_W'(col),
              ROW_FIELD_W'(row));
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (expect_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_color(logic [COLOR_W-1:0] color);
    cfg_wr_data_i = color;
    cfg_wr_en_i   = 1'b1;
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b0;
    text_color_q  = color;
    cfg_cnt++;
  endtask

  task automatic test_reset_screen();
    read_cell(0, 0);
    read_cell(COLS - 1, ROWS - 1);
    read_cell(COLS, 0);
    read_cell(0, ROWS);
    read_cell(127, 31);
  endtask

  task automatic test_control_codes();
    put_char("A");
    put_char(CH_BACKSPACE);
    put_char(CH_BACKSPACE);
    put_char(CH_TAB);
    put_char(CH_RETURN);
    put_char(CH_NEWLINE);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h07);
    read_cell(0, 0);
    read_cell(1, 1);
    read_cell(2, 1);
  endtask

  task automatic test_color_register();
    wait_idle();
    write_color(8'hFF);
    put_char("Z");
    wait_idle();
    write_color(8'h00);
    put_char("z");
    read_cell(3, 1);
    read_cell(4, 1);
  endtask

  task automatic random_item();
    int unsigned         pick;
    logic [CHAR_W-1:0]      ch;
    logic [COL_FIELD_W-1:0] rcol;
    logic [ROW_FIELD_W-1:0] rrow;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    rcol = COL_FIELD_W'($urandom_range(0, 127));
    rrow = ROW_FIELD_W'($urandom_range(0, 31));
    if (pick < 20) begin
      if ($urandom_range(0, 9) != 0) begin
        rcol = COL_FIELD_W'($urandom_range(0, COLS - 1));
        rrow = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
      end
      send_item(FUNC_READ, ch, rcol, rrow);
    end else begin
      if (pick < 30) ch = CH_NEWLINE;
      else if (pick < 35) ch = CH_RETURN;
      else if (pick < 43) ch = CH_BACKSPACE;
      else if (pick < 50) ch = CH_TAB;
      else if (pick < 80) ch = CHAR_W'($urandom_range(32, 126));
      send_item(FUNC_PUT, ch, rcol, rrow);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned        send_pct [4] = '{0, 70, 0, 30};
    int unsigned        stall_pct [4] = '{0, 0, 70, 30};
    logic [COLOR_W-1:0] colors [4];
    colors = '{8'h00, 8'hFF, COLOR_W'($urandom_range(0, 255)),
               COLOR_W'($urandom_range(0, 255))};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_color(colors[p]);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int n = 0; n < 500; n++) begin
        if (n == 250) wait_idle();
        random_item();
      end
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < CELLS; i++) screen_mem[i] = RESET_CELL;
    cur_col = 0;
    cur_row = 0;
    text_color_q = RESET_COLOR;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_screen();
    test_control_codes();
    test_color_register();
    test_random_traffic();
    wait_idle();
    recv_stall_pct = 0;
    repeat (100) @(negedge clk_i);
    $display("Sent %0d items (%0d reads), checked %0d results, saw %0d scrolls.",
             item_cnt, read_cnt, result_cnt, scroll_cnt);
    $display("Color register written %0d times under four idle and stall mixes.", cfg_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_terminal_char_writer.sv
src/tcw_checker.sv
dv/text_terminal_char_writer_tb.sv
